@@ rtl/sab_pkg.sv @@
package sab_pkg;

    // Segmented detector geometry
    localparam int SEGMENTS  = 16;
    localparam int SEG_IDX_W = $clog2(SEGMENTS);

    // Field widths
    localparam int EVT_W     = 32;
    localparam int CRYS_W    = 2;
    localparam int SEGNUM_W  = 5;
    localparam int E_W       = 16;
    localparam int SUM_W     = 20;
    localparam int CENT_W    = 10;
    localparam int CHAN_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int DATA_W    = 72;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Energy-weighted index sum: sum(e * idx) over all segments
    localparam longint WEIGHT_MAX = longint'(SEGMENTS) * 65535 * longint'(SEGMENTS - 1);
    localparam int     WEIGHT_W   = $clog2(WEIGHT_MAX + 1);

    // Centroid divide: quotient of 16*weight / addback, 11 bits, larger clamps
    localparam int CENT_FRAC_W = 4;
    localparam int QUOT_W      = 11;
    localparam int PRE_SHIFT   = QUOT_W - CENT_FRAC_W;
    localparam int STEP_W      = $clog2(QUOT_W);

    localparam logic [CENT_W-1:0] CENT_MAX = '1;
    localparam int                CHAN_LIM = (SEGMENTS - 1 > 15) ? 15 : SEGMENTS - 1;
    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(CHAN_LIM);

    // Register reset values
    localparam logic [E_W-1:0] HIT_THR_RST  = 16'd2;
    localparam logic [E_W-1:0] VETO_THR_RST = 16'd1600;
    localparam logic [E_W-1:0] SUM_TOL_RST  = 16'd80;
    localparam logic [E_W-1:0] FE_WIN_RST   = 16'd160;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIT_THR  = 2'd0,
        CFG_VETO_THR = 2'd1,
        CFG_SUM_TOL  = 2'd2,
        CFG_FE_WIN   = 2'd3
    } cfg_idx_t;

    typedef enum logic [CRYS_W-1:0] {
        CRYS_SEG     = 2'd0,
        CRYS_SCINT_A = 2'd1,
        CRYS_SCINT_B = 2'd2,
        CRYS_SPARE   = 2'd3
    } crystal_t;

    // Input beat payload, lowest field last
    typedef struct packed {
        logic [2:0]          pad;
        logic [E_W-1:0]      primary_energy;
        logic [E_W-1:0]      energy;
        logic [SEGNUM_W-1:0] segment;
        logic [EVT_W-1:0]    event_number;
    } in_data_t;

    // Output beat payload, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic [CHAN_W-1:0] channel;
        logic [CENT_W-1:0] centroid;
        logic [SUM_W-1:0]  addback_energy;
        logic              full_energy;
        logic              vetoed;
        logic              accepted;
        logic [EVT_W-1:0]  closed_event;
    } out_data_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
        logic [SUM_W-1:0]  rem;
    } div_res_t;

endpackage

@@ rtl/sab_store.sv @@
module sab_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          wr_en,
    input  logic [sab_pkg::SEG_IDX_W-1:0] wr_addr,
    input  logic [sab_pkg::E_W-1:0]       wr_data,
    input  logic [sab_pkg::SEG_IDX_W-1:0] rd_addr,
    output logic [sab_pkg::E_W-1:0]       rd_data
);
    import sab_pkg::*;

    logic [E_W-1:0]      energy_reg [SEGMENTS];
    logic [SEGMENTS-1:0] valid_reg;
    logic [SEGMENTS-1:0] valid_next;

    // Valid bits: whole store reads zero after a clear
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Energy entries, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            energy_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = valid_reg[rd_addr] ? energy_reg[rd_addr] : '0;

endmodule

@@ rtl/sab_div.sv @@
module sab_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sab_pkg::WEIGHT_W-1:0] num,
    input  logic [sab_pkg::SUM_W-1:0]    den,
    output sab_pkg::div_res_t            res
);
    import sab_pkg::*;

    localparam int CMP_W = (WEIGHT_W > SUM_W + PRE_SHIFT) ? WEIGHT_W : SUM_W + PRE_SHIFT;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] low_reg, low_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;

    logic              too_big;
    logic [SUM_W:0]    rem_sh;
    logic [SUM_W:0]    rem_sub;
    logic              ge;

    // Quotient would need more than QUOT_W bits: 16*num >= 2^QUOT_W * den
    assign too_big = CMP_W'(num) >= CMP_W'({den, {PRE_SHIFT{1'b0}}});

    // One restoring step: shift in next numerator bit, trial subtract
    assign rem_sh  = {rem_reg, low_reg[QUOT_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start)
        begin
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            ovf_next  = too_big;
            rem_next  = SUM_W'(num >> PRE_SHIFT);
            low_next  = {num[PRE_SHIFT-1:0], {CENT_FRAC_W{1'b0}}};
            busy_next = !too_big;
            done_next = too_big;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            low_next  = {low_reg[QUOT_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

@@ rtl/segment_addback_event_builder.sv @@
// Addback event builder for a segmented detector with veto scintillators.
//
// Input stream (s_*): one hit row per beat. s_tuser carries the crystal code,
// s_tlast marks the last row of the data stream and forces the event to close.
// Output stream (m_*): one beat per closed event; m_tlast is set on the beat
// closed by a last row. A row whose event number differs from the open event
// first closes that event, so one row may cause two beats.
// Configuration: cfg_we/cfg_index/cfg_data write one of the four 16-bit
// thresholds per write; write only while the block is idle.
//
// Sequence: a row that closes nothing passes through apply and back to idle.
// Each close walks the 16-entry segment store one entry per cycle, checks
// the contiguous sum, runs the bit-serial centroid divider when the event
// is accepted (the divider finishes without stepping when the quotient is
// out of range), and loads the output register.
// s_tready is low while a row is being worked on.
// Reset clears thresholds to their defaults, the open event to number 0 and
// the store to empty. A stalled receiver holds the finished beat in the
// output register; the block keeps taking rows until the next close needs it.
module segment_addback_event_builder (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: event_number[31:0], segment[36:32], energy[52:37],
    //          primary_energy[68:53], zero pad[71:69]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sab_pkg::DATA_W-1:0]    s_tdata,
    // s_tuser: crystal[1:0]
    input  logic [sab_pkg::CRYS_W-1:0]    s_tuser,
    input  logic                          s_tlast,
    // m_tdata: closed_event[31:0], accepted[32], vetoed[33], full_energy[34],
    //          addback_energy[54:35], centroid[64:55], channel[68:65], pad[71:69]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sab_pkg::DATA_W-1:0]    m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [sab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sab_pkg::E_W-1:0]       cfg_data
);
    import sab_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPLY  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_EVAL   = 6'b001000,
        S_DIV    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    localparam int PROD_W = E_W + SEG_IDX_W;

    state_t state_reg, state_next;

    // Configuration
    logic [E_W-1:0] hit_thr_reg, hit_thr_next;
    logic [E_W-1:0] veto_thr_reg, veto_thr_next;
    logic [E_W-1:0] sum_tol_reg, sum_tol_next;
    logic [E_W-1:0] fe_win_reg, fe_win_next;

    // Latched row
    logic [EVT_W-1:0]    row_evt_reg, row_evt_next;
    logic [SEGNUM_W-1:0] row_seg_reg, row_seg_next;
    logic [E_W-1:0]      row_energy_reg, row_energy_next;
    logic [E_W-1:0]      row_primary_reg, row_primary_next;
    crystal_t            row_crys_reg, row_crys_next;
    logic                row_last_reg, row_last_next;
    logic                pend_row_reg, pend_row_next;
    logic                eor_reg, eor_next;

    // Open event
    logic [EVT_W-1:0] cur_evt_reg, cur_evt_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic             veto_reg, veto_next;
    logic [E_W-1:0]   primary_reg, primary_next;

    // Scan accumulators
    logic [SEG_IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0]     contig_reg, contig_next;
    logic [WEIGHT_W-1:0]  weight_reg, weight_next;
    logic                 started_reg, started_next;
    logic                 broken_reg, broken_next;

    // Check result
    logic [SUM_W-1:0] addback_reg, addback_next;
    logic             acc_reg, acc_next;

    // Output register
    logic      m_tvalid_reg, m_tvalid_next;
    out_data_t m_data_reg, m_data_next;
    logic      m_last_reg, m_last_next;

    in_data_t       in_row;
    logic           in_acc;
    logic           out_free;
    logic [E_W-1:0] seg_e;
    logic           seg_hit;
    logic [SUM_W:0] contig_sum;
    logic [PROD_W-1:0] prod;
    logic           row_is_hit;
    logic           row_is_veto;
    logic [SUM_W:0] total_sum;
    logic           store_clear;
    logic           store_wr;
    logic [SUM_W-1:0] sum_diff;
    logic [SUM_W-1:0] eval_addback;
    logic           eval_acc;
    logic           div_start;
    div_res_t       div_res;
    logic           rnd;
    logic [QUOT_W:0] cent_sum;
    logic [QUOT_W:0] chan_sum;
    logic [QUOT_W-CENT_FRAC_W:0] chan_raw;
    logic [CENT_W-1:0] cent_val;
    logic [CHAN_W-1:0] chan_val;
    logic [SUM_W-1:0] fe_diff;
    logic           full_val;
    out_data_t      result;

    assign in_row   = in_data_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Segment store
    sab_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (store_clear),
        .wr_en   (store_wr),
        .wr_addr (SEG_IDX_W'(row_seg_reg - 1'b1)),
        .wr_data (row_energy_reg),
        .rd_addr (idx_reg),
        .rd_data (seg_e)
    );

    // Bit-serial centroid divider
    sab_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (weight_reg),
        .den   (eval_addback),
        .res   (div_res)
    );

    // Scan datapath: one segment per cycle
    assign seg_hit    = seg_e >= hit_thr_reg;
    assign contig_sum = {1'b0, contig_reg} + (SUM_W + 1)'(seg_e);
    assign prod       = PROD_W'(seg_e) * PROD_W'(idx_reg);

    // Row qualification
    assign row_is_hit  = (row_crys_reg == CRYS_SEG) && (row_energy_reg >= hit_thr_reg)
                         && (row_seg_reg != '0) && (32'(row_seg_reg) <= SEGMENTS);
    assign row_is_veto = ((row_crys_reg == CRYS_SCINT_A) || (row_crys_reg == CRYS_SCINT_B))
                         && (row_energy_reg > veto_thr_reg);
    assign total_sum   = {1'b0, total_reg} + (SUM_W + 1)'(row_energy_reg);
    assign store_wr    = (state_reg == S_APPLY) && row_is_hit;
    assign store_clear = (state_reg == S_FINISH) && out_free;

    // Contiguity check
    assign sum_diff     = (contig_reg >= total_reg) ? contig_reg - total_reg
                                                    : total_reg - contig_reg;
    assign eval_addback = (sum_diff > SUM_W'(sum_tol_reg)) ? '0 : total_reg;
    assign eval_acc     = (eval_addback != '0) && (eval_addback >= SUM_W'(hit_thr_reg));
    assign div_start    = (state_reg == S_EVAL) && eval_acc;

    // Centroid and channel from quotient of 16*weight / addback
    assign rnd      = {div_res.rem, 1'b0} >= {1'b0, addback_reg};
    assign cent_sum = {1'b0, div_res.quot} + (QUOT_W + 1)'(rnd);
    assign chan_sum = {1'b0, div_res.quot} + (QUOT_W + 1)'(1 << (CENT_FRAC_W - 1));
    assign chan_raw = chan_sum[QUOT_W:CENT_FRAC_W];
    assign cent_val = (div_res.ovf || cent_sum > (QUOT_W + 1)'(CENT_MAX))
                      ? CENT_MAX : cent_sum[CENT_W-1:0];
    assign chan_val = (div_res.ovf || chan_raw > (QUOT_W - CENT_FRAC_W + 1)'(CHAN_MAX))
                      ? CHAN_MAX : chan_raw[CHAN_W-1:0];

    // Full-energy match
    assign fe_diff  = (addback_reg >= SUM_W'(primary_reg)) ? addback_reg - SUM_W'(primary_reg)
                                                           : SUM_W'(primary_reg) - addback_reg;
    assign full_val = acc_reg && !veto_reg && (fe_diff < SUM_W'(fe_win_reg));

    always_comb
    begin
        result                = '0;
        result.closed_event   = cur_evt_reg;
        result.accepted       = acc_reg;
        result.vetoed         = veto_reg;
        result.full_energy    = full_val;
        result.addback_energy = acc_reg ? addback_reg : '0;
        result.centroid       = acc_reg ? cent_val : '0;
        result.channel        = acc_reg ? chan_val : '0;
    end

    // Configuration writes
    always_comb
    begin
        hit_thr_next  = hit_thr_reg;
        veto_thr_next = veto_thr_reg;
        sum_tol_next  = sum_tol_reg;
        fe_win_next   = fe_win_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HIT_THR:  hit_thr_next  = cfg_data;
                CFG_VETO_THR: veto_thr_next = cfg_data;
                CFG_SUM_TOL:  sum_tol_next  = cfg_data;
                CFG_FE_WIN:   fe_win_next   = cfg_data;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        row_evt_next     = row_evt_reg;
        row_seg_next     = row_seg_reg;
        row_energy_next  = row_energy_reg;
        row_primary_next = row_primary_reg;
        row_crys_next    = row_crys_reg;
        row_last_next    = row_last_reg;
        pend_row_next    = pend_row_reg;
        eor_next         = eor_reg;
        cur_evt_next     = cur_evt_reg;
        total_next       = total_reg;
        veto_next        = veto_reg;
        primary_next     = primary_reg;
        idx_next         = idx_reg;
        contig_next      = contig_reg;
        weight_next      = weight_reg;
        started_next     = started_reg;
        broken_next      = broken_reg;
        addback_next     = addback_reg;
        acc_next         = acc_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    row_evt_next     = in_row.event_number;
                    row_seg_next     = in_row.segment;
                    row_energy_next  = in_row.energy;
                    row_primary_next = in_row.primary_energy;
                    row_crys_next    = crystal_t'(s_tuser);
                    row_last_next    = s_tlast;
                    if (in_row.event_number != cur_evt_reg)
                    begin
                        pend_row_next = 1'b1;
                        eor_next      = 1'b0;
                        idx_next      = '0;
                        contig_next   = '0;
                        weight_next   = '0;
                        started_next  = 1'b0;
                        broken_next   = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                pend_row_next = 1'b0;
                primary_next  = row_primary_reg;
                if (row_is_veto)
                begin
                    veto_next = 1'b1;
                end
                if (row_is_hit)
                begin
                    total_next = total_sum[SUM_W] ? SUM_MAX : total_sum[SUM_W-1:0];
                end
                if (row_last_reg)
                begin
                    eor_next     = 1'b1;
                    idx_next     = '0;
                    contig_next  = '0;
                    weight_next  = '0;
                    started_next = 1'b0;
                    broken_next  = 1'b0;
                    state_next   = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // First contiguous run of hit segments, lowest index first
                if (seg_hit && !broken_reg)
                begin
                    contig_next  = contig_sum[SUM_W] ? SUM_MAX : contig_sum[SUM_W-1:0];
                    weight_next  = weight_reg + WEIGHT_W'(prod);
                    started_next = 1'b1;
                end
                else if (!seg_hit && started_reg)
                begin
                    broken_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SEG_IDX_W'(SEGMENTS - 1))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                addback_next = eval_addback;
                acc_next     = eval_acc;
                state_next   = eval_acc ? S_DIV : S_FINISH;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = result;
                    m_last_next   = eor_reg;
                    total_next    = '0;
                    veto_next     = 1'b0;
                    primary_next  = '0;
                    if (pend_row_reg)
                    begin
                        cur_evt_next = row_evt_reg;
                        state_next   = S_APPLY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hit_thr_reg  <= HIT_THR_RST;
            veto_thr_reg <= VETO_THR_RST;
            sum_tol_reg  <= SUM_TOL_RST;
            fe_win_reg   <= FE_WIN_RST;
            pend_row_reg <= 1'b0;
            eor_reg      <= 1'b0;
            row_last_reg <= 1'b0;
            cur_evt_reg  <= '0;
            total_reg    <= '0;
            veto_reg     <= 1'b0;
            primary_reg  <= '0;
            idx_reg      <= '0;
            started_reg  <= 1'b0;
            broken_reg   <= 1'b0;
            acc_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hit_thr_reg  <= hit_thr_next;
            veto_thr_reg <= veto_thr_next;
            sum_tol_reg  <= sum_tol_next;
            fe_win_reg   <= fe_win_next;
            pend_row_reg <= pend_row_next;
            eor_reg      <= eor_next;
            row_last_reg <= row_last_next;
            cur_evt_reg  <= cur_evt_next;
            total_reg    <= total_next;
            veto_reg     <= veto_next;
            primary_reg  <= primary_next;
            idx_reg      <= idx_next;
            started_reg  <= started_next;
            broken_reg   <= broken_next;
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
            m_last_reg   <= m_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_evt_reg     <= row_evt_next;
        row_seg_reg     <= row_seg_next;
        row_energy_reg  <= row_energy_next;
        row_primary_reg <= row_primary_next;
        row_crys_reg    <= row_crys_next;
        contig_reg      <= contig_next;
        weight_reg      <= weight_next;
        addback_reg     <= addback_next;
        m_data_reg      <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/sab_checker.sv @@
module sab_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [sab_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast
);
    import sab_pkg::*;

    out_data_t od;

    assign od = out_data_t'(m_tdata);

    // Stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed under stall");

    // A taken row keeps the block busy, so no row is taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("row accepted back to back");

    // Rejected event carries no energy, centroid or channel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !od.accepted |->
            od.addback_energy == '0 && od.centroid == '0 && od.channel == '0)
    else $error("rejected event with nonzero payload");

    // Full-energy match needs an accepted, unvetoed event with nonzero addback
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && od.full_energy |->
            od.accepted && !od.vetoed && od.addback_energy != '0)
    else $error("full energy flag without accepted event");

endmodule

bind segment_addback_event_builder sab_checker u_sab_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ dv/segment_addback_event_builder_checker.sv @@
module segment_addback_event_builder_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: event_number, segment, energy, primary_energy, pad
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sab_pkg::DATA_W-1:0]    s_tdata,
    // s_tuser: crystal
    input  logic [sab_pkg::CRYS_W-1:0]    s_tuser,
    input  logic                          s_tlast,
    // m_tdata: closed_event, accepted, vetoed, full_energy, addback_energy,
    //          centroid, channel, pad
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sab_pkg::DATA_W-1:0]    m_tdata,
    input  logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [sab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sab_pkg::E_W-1:0]       cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import sab_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [EVT_W-1:0]  closed_event;
        logic              accepted;
        logic              vetoed;
        logic              full_energy;
        logic [SUM_W-1:0]  addback;
        logic [CENT_W-1:0] centroid;
        logic [CHAN_W-1:0] channel;
        logic              end_of_run;
    } event_summary_t;

    // Thresholds as last written
    logic [E_W-1:0]   hit_thr;
    logic [E_W-1:0]   veto_thr;
    logic [E_W-1:0]   sum_tol;
    logic [E_W-1:0]   fe_win;

    // Open event
    logic [E_W-1:0]   seg_store [SEGMENTS];
    logic [SUM_W-1:0] running_total;
    logic [EVT_W-1:0] open_event;
    logic             veto_flag;
    logic [E_W-1:0]   latched_primary;

    event_summary_t   summaries_due [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void clear_open_event();
        for (int i = 0; i < SEGMENTS; i++)
            seg_store[i] = '0;
        running_total   = '0;
        veto_flag       = 1'b0;
        latched_primary = '0;
    endfunction

    // Close the open event: first contiguous run, tolerance check, centroid
    function automatic event_summary_t build_summary(input logic eor);
        event_summary_t r;
        u64_t run_sum;
        u64_t weight;
        u64_t total;
        u64_t q_cent;
        u64_t q_chan;
        u64_t diff;
        bit   in_run;
        bit   run_done;
        r        = '0;
        run_sum  = 0;
        weight   = 0;
        in_run   = 1'b0;
        run_done = 1'b0;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            if (!run_done)
            begin
                if (seg_store[i] >= hit_thr)
                begin
                    run_sum += u64_t'(seg_store[i]);
                    if (run_sum > u64_t'(SUM_MAX))
                        run_sum = u64_t'(SUM_MAX);
                    weight += u64_t'(seg_store[i]) * u64_t'(i);
                    in_run = 1'b1;
                end
                else if (in_run)
                    run_done = 1'b1;
            end
        end
        total = u64_t'(running_total);
        diff  = (run_sum > total) ? run_sum - total : total - run_sum;
        if (diff > u64_t'(sum_tol))
            total = 0;
        r.accepted = (total != 0) && (total >= u64_t'(hit_thr));
        if (r.accepted)
        begin
            q_cent = (weight * 32 + total) / (2 * total);
            if (q_cent > u64_t'(CENT_MAX))
                q_cent = u64_t'(CENT_MAX);
            q_chan = (weight * 2 + total) / (2 * total);
            if (q_chan > u64_t'(CHAN_LIM))
                q_chan = u64_t'(CHAN_LIM);
            diff = (total > u64_t'(latched_primary)) ? total - u64_t'(latched_primary)
                                                     : u64_t'(latched_primary) - total;
            r.full_energy = !veto_flag && (diff < u64_t'(fe_win));
            r.addback     = total[SUM_W-1:0];
            r.centroid    = q_cent[CENT_W-1:0];
            r.channel     = q_chan[CHAN_W-1:0];
        end
        r.closed_event = open_event;
        r.vetoed       = veto_flag;
        r.end_of_run   = eor;
        return r;
    endfunction

    function automatic void check_field(input string name, input u64_t want, input u64_t got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        in_data_t       row;
        out_data_t      beat;
        crystal_t       crys;
        event_summary_t want;
        logic [SUM_W:0] grown;
        if (!rst_n)
        begin
            hit_thr    = HIT_THR_RST;
            veto_thr   = VETO_THR_RST;
            sum_tol    = SUM_TOL_RST;
            fe_win     = FE_WIN_RST;
            open_event = '0;
            clear_open_event();
            summaries_due.delete();
            pending = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HIT_THR:  hit_thr  = cfg_data;
                    CFG_VETO_THR: veto_thr = cfg_data;
                    CFG_SUM_TOL:  sum_tol  = cfg_data;
                    CFG_FE_WIN:   fe_win   = cfg_data;
                    default: ;
                endcase
            end

            // input beat: close on event change, accumulate, close on last row
            if (s_tvalid && s_tready)
            begin
                row  = in_data_t'(s_tdata);
                crys = crystal_t'(s_tuser);
                if (row.event_number != open_event)
                begin
                    summaries_due.push_back(build_summary(1'b0));
                    clear_open_event();
                    open_event = row.event_number;
                end
                latched_primary = row.primary_energy;
                if ((crys == CRYS_SCINT_A || crys == CRYS_SCINT_B) && row.energy > veto_thr)
                    veto_flag = 1'b1;
                if (crys == CRYS_SEG && row.energy >= hit_thr && row.segment >= 1
                    && row.segment <= SEGMENTS)
                begin
                    grown = running_total + row.energy;
                    running_total = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
                    seg_store[row.segment - 1] = row.energy;
                end
                if (s_tlast)
                begin
                    summaries_due.push_back(build_summary(1'b1));
                    clear_open_event();
                end
            end

            // output beat against oldest expectation
            if (m_tvalid && m_tready)
            begin
                beat = out_data_t'(m_tdata);
                if (summaries_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat, expected none actual %h", $time, m_tdata);
                end
                else
                begin
                    want = summaries_due.pop_front();
                    check_field("closed_event", want.closed_event, beat.closed_event);
                    check_field("accepted", want.accepted, beat.accepted);
                    check_field("vetoed", want.vetoed, beat.vetoed);
                    check_field("full_energy", want.full_energy, beat.full_energy);
                    check_field("addback_energy", want.addback, beat.addback_energy);
                    check_field("centroid", want.centroid, beat.centroid);
                    check_field("channel", want.channel, beat.channel);
                    check_field("end_of_run", want.end_of_run, m_tlast);
                end
            end
            pending = summaries_due.size();
        end
    end

endmodule

@@ dv/segment_addback_event_builder_tb.sv @@
module segment_addback_event_builder_tb;

    import sab_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic [CRYS_W-1:0]    s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [E_W-1:0]       cfg_data;
    int                   fail_count;
    int                   pending;

    // Settings in force, used to shape stimulus
    logic [E_W-1:0]       hit_thr_now;
    logic [E_W-1:0]       veto_thr_now;
    logic [E_W-1:0]       fe_win_now;
    logic [EVT_W-1:0]     ev_now;
    int unsigned          row_count;
    bit                   calm;
    bit                   squeeze;
    bit                   squeeze_done;
    bit                   tx_steady;

    segment_addback_event_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    segment_addback_event_builder_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stall bursts, steady windows, one long hold-off
    initial
    begin
        int unsigned rx_mode;
        int unsigned rx_window;
        m_tready  = 1'b0;
        rx_mode   = 0;
        rx_window = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_window == 0)
            begin
                rx_mode   = $urandom_range(0, 2);
                rx_window = 150;
            end
            rx_window--;
            if (squeeze && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && rx_mode != 0 && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One input row; returns after the beat is taken
    task automatic send_row(input logic [EVT_W-1:0] ev, input crystal_t crys,
                            input logic [SEGNUM_W-1:0] seg, input logic [E_W-1:0] e,
                            input logic [E_W-1:0] prim, input logic last);
        in_data_t d;
        d                = '0;
        d.event_number   = ev;
        d.segment        = seg;
        d.energy         = e;
        d.primary_energy = prim;
        if (!calm && !tx_steady && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= crys;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!(crys == CRYS_SPARE || (crys == CRYS_SEG && (seg == 0 || seg > SEGMENTS))))
            row_count++;
    endtask

    // Stop offering, wait for every expected beat, then let the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [E_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [E_W-1:0] hit, input logic [E_W-1:0] veto,
                                input logic [E_W-1:0] tol, input logic [E_W-1:0] win);
        settle();
        put_reg(CFG_HIT_THR, hit);
        put_reg(CFG_VETO_THR, veto);
        put_reg(CFG_SUM_TOL, tol);
        put_reg(CFG_FE_WIN, win);
        cfg_we       <= 1'b0;
        hit_thr_now  = hit;
        veto_thr_now = veto;
        fe_win_now   = win;
    endtask

    // Energy that counts as a hit under the current threshold
    function automatic logic [E_W-1:0] hit_energy();
        int unsigned span;
        span = 65535 - hit_thr_now;
        if (span > 3000 && $urandom_range(0, 7) != 0)
            span = 3000;
        return E_W'(hit_thr_now + $urandom_range(0, span));
    endfunction

    function automatic logic [E_W-1:0] near_hit_energy();
        if (hit_thr_now > 65495)
            return 16'hFFFF;
        return E_W'(hit_thr_now + $urandom_range(0, 40));
    endfunction

    function automatic logic [E_W-1:0] clip16(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return v[E_W-1:0];
    endfunction

    // One event: mostly well-formed runs, some split or repeated, some noise
    task automatic run_event();
        logic [SEGNUM_W-1:0] segs [SEGMENTS+2];
        logic [E_W-1:0]      energies [SEGMENTS+2];
        logic [SEGNUM_W-1:0] seg_a;
        logic [SEGNUM_W-1:0] tmp_seg;
        logic [E_W-1:0]      tmp_e;
        logic [E_W-1:0]      prim;
        crystal_t            crys;
        int unsigned         kind;
        int unsigned         len;
        int unsigned         n;
        int unsigned         sum;
        int unsigned         j;
        logic                end_flag;

        if ($urandom_range(0, 15) == 0)
            tx_steady = !tx_steady;
        case ($urandom_range(0, 15))
            0:       ev_now = $urandom();
            1:       ev_now = ev_now;
            default: ev_now = ev_now + 1;
        endcase
        kind     = $urandom_range(0, 9);
        end_flag = ($urandom_range(0, 7) == 0);
        n        = 0;
        sum      = 0;

        if (kind == 8)
        begin
            // fully random rows
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                send_row(ev_now, crystal_t'($urandom_range(0, 3)),
                         SEGNUM_W'($urandom_range(0, 31)),
                         E_W'($urandom_range(0, 65535)), E_W'($urandom_range(0, 65535)),
                         (k == len - 1) && end_flag);
        end
        else if (kind == 9)
        begin
            // rows that add no hit or veto: spare crystal, guard ring, out of range
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 2))
                    0: send_row(ev_now, CRYS_SPARE, SEGNUM_W'($urandom_range(0, 31)),
                                E_W'($urandom_range(0, 65535)),
                                E_W'($urandom_range(0, 65535)),
                                (k == len - 1) && end_flag);
                    1: send_row(ev_now, CRYS_SEG, '0, E_W'($urandom_range(0, 65535)),
                                E_W'($urandom_range(0, 65535)),
                                (k == len - 1) && end_flag);
                    default: send_row(ev_now, CRYS_SEG,
                                      SEGNUM_W'($urandom_range(SEGMENTS + 1, 31)),
                                      E_W'($urandom_range(0, 65535)),
                                      E_W'($urandom_range(0, 65535)),
                                      (k == len - 1) && end_flag);
                endcase
            end
        end
        else
        begin
            // contiguous run, optionally split or with a repeated segment
            seg_a = SEGNUM_W'($urandom_range(1, SEGMENTS));
            len   = $urandom_range(1, 6);
            if (seg_a + len > SEGMENTS + 1)
                len = SEGMENTS + 1 - seg_a;
            for (int k = 0; k < len; k++)
            begin
                segs[n]     = SEGNUM_W'(seg_a + k);
                energies[n] = hit_energy();
                sum += energies[n];
                n++;
            end
            if (kind == 6 && seg_a + len + 1 <= SEGMENTS)
            begin
                segs[n]     = SEGNUM_W'(seg_a + len + 1);
                energies[n] = $urandom_range(0, 1) ? hit_energy() : near_hit_energy();
                sum += energies[n];
                n++;
            end
            if (kind == 7)
            begin
                segs[n]     = segs[$urandom_range(0, n - 1)];
                energies[n] = $urandom_range(0, 1) ? hit_energy() : near_hit_energy();
                sum += energies[n];
                n++;
            end
            // shuffle row order
            for (int k = n - 1; k > 0; k--)
            begin
                j           = $urandom_range(0, k);
                tmp_seg     = segs[k];
                tmp_e       = energies[k];
                segs[k]     = segs[j];
                energies[k] = energies[j];
                segs[j]     = tmp_seg;
                energies[j] = tmp_e;
            end
            if ($urandom_range(0, 3) == 0)
                prim = E_W'($urandom_range(0, 65535));
            else
                prim = clip16(int'(sum) + int'($urandom_range(0, 2 * fe_win_now + 6))
                              - int'(fe_win_now) - 3);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    crys = $urandom_range(0, 1) ? CRYS_SCINT_A : CRYS_SCINT_B;
                    send_row(ev_now, crys, SEGNUM_W'($urandom_range(0, 31)),
                             clip16(int'(veto_thr_now) + int'($urandom_range(0, 2)) - 1),
                             prim, 1'b0);
                end
                if (hit_thr_now > 0 && $urandom_range(0, 7) == 0)
                    send_row(ev_now, CRYS_SEG, SEGNUM_W'($urandom_range(1, SEGMENTS)),
                             E_W'($urandom_range(0, hit_thr_now - 1)), prim, 1'b0);
                send_row(ev_now, CRYS_SEG, segs[k], energies[k], prim,
                         (k == n - 1) && end_flag);
            end
        end
    endtask

    task automatic run_phase(input int unsigned rows);
        int unsigned target;
        target = row_count + rows;
        while (row_count < target)
            run_event();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CRYS_SEG;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_HIT_THR;
        cfg_data     = '0;
        hit_thr_now  = HIT_THR_RST;
        veto_thr_now = VETO_THR_RST;
        fe_win_now   = FE_WIN_RST;
        ev_now       = '0;
        row_count    = 0;
        calm         = 1'b0;
        squeeze      = 1'b0;
        squeeze_done = 1'b0;
        tx_steady    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty event 0 closes first; three-segment event at full energy
        send_row(32'd1, CRYS_SEG, 5'd1, 16'd1000, 16'd3000, 1'b0);
        send_row(32'd1, CRYS_SEG, 5'd2, 16'd1000, 16'd3000, 1'b0);
        send_row(32'd1, CRYS_SEG, 5'd3, 16'd1000, 16'd3000, 1'b0);
        // top segment at full scale, scintillators just above and at threshold
        send_row(32'd2, CRYS_SEG, 5'd16, 16'hFFFF, 16'hFFFF, 1'b0);
        send_row(32'd2, CRYS_SCINT_B, 5'd0, 16'd1601, 16'hFFFF, 1'b0);
        send_row(32'd2, CRYS_SCINT_A, 5'd0, 16'd1600, 16'hFFFF, 1'b0);
        // split run, plus guard ring, out-of-range segments and spare crystal
        send_row(32'd3, CRYS_SEG, 5'd1, 16'd500, 16'd1000, 1'b0);
        send_row(32'd3, CRYS_SEG, 5'd3, 16'd500, 16'd1000, 1'b0);
        send_row(32'd3, CRYS_SEG, 5'd0, 16'd900, 16'd1000, 1'b0);
        send_row(32'd3, CRYS_SEG, 5'd17, 16'd900, 16'd1000, 1'b0);
        send_row(32'd3, CRYS_SEG, 5'd31, 16'd900, 16'd1000, 1'b0);
        send_row(32'd3, CRYS_SPARE, 5'd2, 16'd900, 16'd1000, 1'b0);
        // below threshold, then the same segment twice
        send_row(32'd4, CRYS_SEG, 5'd5, 16'd1, 16'd600, 1'b0);
        send_row(32'd4, CRYS_SEG, 5'd5, 16'd300, 16'd600, 1'b0);
        send_row(32'd4, CRYS_SEG, 5'd5, 16'd300, 16'd600, 1'b0);
        // event change and last row together: two beats
        send_row(32'hFFFF_FFFF, CRYS_SEG, 5'd4, 16'd2000, 16'd2000, 1'b1);
        // same number after the close, primary zero
        send_row(32'hFFFF_FFFF, CRYS_SEG, 5'd8, 16'd70, 16'd0, 1'b1);
        // left open for the random part
        send_row(32'd7, CRYS_SEG, 5'd9, 16'h5555, 16'hAAAA, 1'b0);
        ev_now = 32'd7;

        // default thresholds, with the long receiver hold-off
        program_regs(HIT_THR_RST, VETO_THR_RST, SUM_TOL_RST, FE_WIN_RST);
        run_phase(100);
        squeeze = 1'b1;
        run_phase(400);

        // all thresholds zero, with an all-zero-energy event
        program_regs('0, '0, '0, '0);
        ev_now = ev_now + 1;
        send_row(ev_now, CRYS_SEG, 5'd3, 16'd0, 16'd0, 1'b0);
        send_row(ev_now, CRYS_SEG, 5'd4, 16'd0, 16'd0, 1'b1);
        run_phase(150);

        // all thresholds at full scale, with a saturating total
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        ev_now = ev_now + 1;
        for (int s = 1; s <= SEGMENTS; s++)
            send_row(ev_now, CRYS_SEG, SEGNUM_W'(s), 16'hFFFF, 16'hFFFF, 1'b0);
        send_row(ev_now, CRYS_SEG, 5'd1, 16'hFFFF, 16'hFFFF, 1'b1);
        run_phase(100);

        // random mid-range settings
        for (int p = 0; p < 3; p++)
        begin
            program_regs(E_W'($urandom_range(0, 200)), E_W'($urandom_range(0, 4000)),
                         E_W'($urandom_range(0, 300)), E_W'($urandom_range(0, 500)));
            run_phase(250);
        end

        // closing stretch without idling
        program_regs(HIT_THR_RST, VETO_THR_RST, SUM_TOL_RST, FE_WIN_RST);
        calm = 1'b1;
        run_phase(250);

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sab_pkg.sv
rtl/sab_store.sv
rtl/sab_div.sv
rtl/segment_addback_event_builder.sv
rtl/sab_checker.sv
dv/segment_addback_event_builder_checker.sv
dv/segment_addback_event_builder_tb.sv
